// File: rtl/mexp_pkg.sv
package mexp_pkg;

  // Width of each field on the stream ports
  localparam int unsigned FIELD_WIDTH = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_RED,
    S_DONE
  } state_t;

endpackage

// File: rtl/modular_exponentiation_core.sv
// Computes base^exponent mod modulus by right-to-left square and multiply,
// one item at a time. Only the low OPERAND_WIDTH (W) bits of each field are
// used. One shared W x W multiplier and one restoring remainder unit, which
// takes one product bit per cycle, do all the arithmetic. Every modular
// product is a multiply (S_MUL) followed by a reduction over all 2W product
// bits (S_RED). Each modular product is preceded by a decision state
// (S_CHECK), and one more decision ends the exponent scan. An item with
// exponent zero goes from its first decision to the result, and an item with
// modulus zero skips the scan entirely. A zero modulus returns residue 0
// with tuser set. The result sits in an output register, so the next item
// is taken while it waits.
module modular_exponentiation_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // base [31:0], exponent [63:32], modulus [95:64]
  input  logic [3*mexp_pkg::FIELD_WIDTH-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // power_residue [31:0]
  output logic [mexp_pkg::FIELD_WIDTH-1:0]     m_tdata,
  // zero_modulus_error [0]
  output logic                                 m_tuser
);
  import mexp_pkg::*;

  localparam int unsigned W      = OPERAND_WIDTH;
  localparam int unsigned CNT_W  = $clog2(2 * W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * W - 1);

  state_t state, state_next;

  logic [W-1:0]     acc;
  logic [W-1:0]     sq;
  logic [W-1:0]     expo;
  logic [W-1:0]     mod_r;
  logic             mul_acc;   // current product updates the accumulator
  logic             sq_phase;  // multiply for this bit already done
  logic [2*W-1:0]   prod;
  logic [W-1:0]     rem;
  logic [CNT_W-1:0] cnt;

  logic             out_load;
  logic             red_last;
  logic [W:0]       rem_shift;
  logic [W+1:0]     diff;
  logic [W-1:0]     rem_new;
  logic [W-1:0]     mul_a;
  logic [W-1:0]     residue;

  // Remainder step: bring in the next product bit, subtract if it fits
  assign rem_shift = {rem, prod[2*W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, mod_r};
  assign rem_new   = diff[W+1] ? rem_shift[W-1:0] : diff[W-1:0];
  assign red_last  = (cnt == CNT_LAST);

  assign mul_a   = mul_acc ? acc : sq;
  // Accumulator is reduced unless untouched; 1 mod 1 is the only fix-up
  assign residue = (mod_r == W'(1)) ? '0 : acc;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tdata[2*FIELD_WIDTH +: W] == '0) state_next = S_DONE;
          else state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (expo == '0) state_next = S_DONE;
        else state_next = S_MUL;
      end
      S_MUL: state_next = S_RED;
      S_RED: begin
        if (red_last) state_next = S_CHECK;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and load strobes
  always_comb begin
    s_tready = (state == S_IDLE);
    out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Operand registers and shared datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          sq       <= s_tdata[0 +: W];
          expo     <= s_tdata[FIELD_WIDTH +: W];
          mod_r    <= s_tdata[2*FIELD_WIDTH +: W];
          acc      <= W'(1);
          sq_phase <= 1'b0;
        end
      end
      S_CHECK: begin
        mul_acc <= expo[0] && !sq_phase;
      end
      S_MUL: begin
        prod <= (2*W)'(mul_a) * (2*W)'(sq);
        rem  <= '0;
        cnt  <= '0;
      end
      S_RED: begin
        prod <= prod << 1;
        rem  <= rem_new;
        cnt  <= cnt + CNT_W'(1);
        if (red_last) begin
          if (mul_acc) begin
            acc      <= rem_new;
            sq_phase <= 1'b1;
          end else begin
            sq       <= rem_new;
            expo     <= expo >> 1;
            sq_phase <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= (mod_r == '0);
      m_tdata <= (mod_r == '0) ? '0 : FIELD_WIDTH'(residue);
    end
  end

endmodule

// File: rtl/mexp_checker.sv
module mexp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Error beat carries a zero residue
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'd0)
    else $error("error beat with nonzero residue");

  // Block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again without working");

  // Reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
